>>> design/dts_pkg.sv
// Shared types and constants for the DMA transfer splitter.
// Used by dts_front, dts_queue, dts_back and the top level; no dependencies.
package dts_pkg;

  // Default configuration of the splitter
  localparam int MAX_BULK_BYTES_DEF     = 16384;
  localparam int WINDOW_CHUNK_BYTES_DEF = 1024;
  localparam int NUM_WINDOWS_DEF        = 2;
  localparam int QUEUE_DEPTH_DEF        = 4;

  // Field widths
  localparam int ADDR_W  = 64;
  localparam int LOCAL_W = 18;
  localparam int COUNT_W = 16;
  localparam int SLOT_W  = 4;
  localparam int BYTES_W = 15;

  // Address geometry
  localparam int LINE_BITS   = 4;
  localparam int OFFSET_BITS = 26;
  localparam int GROUP_W     = 3;

  // At most this many chunks per request
  localparam int RESULT_LIMIT = 64;

  // Configuration register map
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_WINDOW_SPACE_BASE = 3'd0;

  typedef enum logic {
    OP_TRANSFER,
    OP_TABLE_WRITE
  } req_op_t;

  // Classified request as held in the queue. For a table write, addr carries
  // the new entry and slot the entry index; for a windowed transfer addr is
  // already relative to the window-space base.
  typedef struct packed {
    req_op_t             op;
    logic                windowed;
    logic [ADDR_W-1:0]   addr;
    logic [LOCAL_W-1:0]  local_addr;
    logic [COUNT_W-1:0]  size;
    logic [SLOT_W-1:0]   slot;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> design/dma_transfer_splitter_core.sv
// DMA transfer splitter: cuts write requests into legal DMA chunks, with a
// window table and an APB-style register for the window-space base.
// Depends on dts_pkg, dts_front, dts_queue and dts_back.
//
// The front end takes a request in any cycle the request queue has room;
// transfers with a zero byte count or mismatched low address bits in the
// direct path are dropped there and never reach the chunk generator. The
// chunk generator takes a request from the queue while idle (a table write
// completes in that cycle) and then emits its chunks in turn; the output
// register lets a chunk of the same transfer be taken every cycle while pop
// is held. Windowed chunks are translated through a 16-entry table that
// holds no value until written; a chunk that reads an entry never written
// carries an undefined remote address.
module dma_transfer_splitter_core
  import dts_pkg::*;
#(
  parameter int MAX_BULK_BYTES     = MAX_BULK_BYTES_DEF,
  parameter int WINDOW_CHUNK_BYTES = WINDOW_CHUNK_BYTES_DEF,
  parameter int NUM_WINDOWS        = NUM_WINDOWS_DEF,
  parameter int QUEUE_DEPTH        = QUEUE_DEPTH_DEF
)(
  input  logic                  clk,
  input  logic                  rst,
  // Register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [ADDR_W-1:0]     pwdata,
  output logic [ADDR_W-1:0]     prdata,
  output logic                  pready,
  // Request side
  input  logic                  push,
  output logic                  full,
  input  logic                  mode,
  input  logic [ADDR_W-1:0]     effective_address,
  input  logic [LOCAL_W-1:0]    local_address,
  input  logic [COUNT_W-1:0]    byte_count,
  input  logic [SLOT_W-1:0]     window_slot,
  input  logic [ADDR_W-1:0]     window_base,
  // Chunk side
  output logic                  empty,
  input  logic                  pop,
  output logic [ADDR_W-1:0]     chunk_remote_address,
  output logic [LOCAL_W-1:0]    chunk_local_address,
  output logic [BYTES_W-1:0]    chunk_bytes,
  output logic                  last_chunk
);

  logic [ADDR_W-1:0] window_space_base;
  logic              q_push;
  logic              q_pop;
  req_t              q_req;
  req_t              q_head;
  queue_status_t     q_status;

  // Register port: single base register, always ready
  assign pready = 1'b1;
  assign prdata = (paddr == CFG_ADDR_WINDOW_SPACE_BASE) ? window_space_base : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_space_base <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr == CFG_ADDR_WINDOW_SPACE_BASE) begin
      window_space_base <= pwdata;
    end
  end

  // Classify incoming requests
  dts_front u_front (
    .push              (push),
    .full              (full),
    .mode              (mode),
    .effective_address (effective_address),
    .local_address     (local_address),
    .byte_count        (byte_count),
    .window_slot       (window_slot),
    .window_base       (window_base),
    .window_space_base (window_space_base),
    .q_status          (q_status),
    .q_push            (q_push),
    .q_req             (q_req)
  );

  // Decouple front end from chunk generator
  dts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_req (q_req),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  // Cut requests into chunks
  dts_back #(
    .MAX_BULK_BYTES     (MAX_BULK_BYTES),
    .WINDOW_CHUNK_BYTES (WINDOW_CHUNK_BYTES),
    .NUM_WINDOWS        (NUM_WINDOWS)
  ) u_back (
    .clk                  (clk),
    .rst                  (rst),
    .head                 (q_head),
    .q_status             (q_status),
    .q_pop                (q_pop),
    .empty                (empty),
    .pop                  (pop),
    .chunk_remote_address (chunk_remote_address),
    .chunk_local_address  (chunk_local_address),
    .chunk_bytes          (chunk_bytes),
    .last_chunk           (last_chunk)
  );

`ifndef SYNTH
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("request queue written while full");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("request queue read while empty");

  a_chunk_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> chunk_bytes != '0)
    else $error("chunk of zero length offered");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("chunk offered straight after reset");
`endif

endmodule

>>> design/dts_front.sv
// Request front end: accepts requests, classifies them and queues the work.
// Depends on dts_pkg.
module dts_front
  import dts_pkg::*;
(
  input  logic                push,
  output logic                full,
  input  logic                mode,
  input  logic [ADDR_W-1:0]   effective_address,
  input  logic [LOCAL_W-1:0]  local_address,
  input  logic [COUNT_W-1:0]  byte_count,
  input  logic [SLOT_W-1:0]   window_slot,
  input  logic [ADDR_W-1:0]   window_base,
  input  logic [ADDR_W-1:0]   window_space_base,
  input  queue_status_t       q_status,
  output logic                q_push,
  output req_t                q_req
);

  logic              accept;
  logic              windowed;
  logic              mismatch;
  logic [ADDR_W-1:0] rel_addr;

  assign full   = q_status.full;
  assign accept = push & ~q_status.full;

  // Classify: windowed when the address covers every base bit
  assign windowed = (effective_address & window_space_base) == window_space_base;
  assign rel_addr = effective_address - window_space_base;
  assign mismatch = effective_address[LINE_BITS-1:0] != local_address[LINE_BITS-1:0];

  // Build the queue entry; drop empty transfers and misaligned direct transfers
  always_comb begin
    q_req.local_addr = local_address;
    q_req.size       = byte_count;
    q_req.slot       = window_slot;
    q_req.windowed   = windowed;
    if (mode) begin
      q_req.op   = OP_TABLE_WRITE;
      q_req.addr = window_base;
      q_push     = accept;
    end else begin
      q_req.op   = OP_TRANSFER;
      q_req.addr = windowed ? rel_addr : effective_address;
      q_push     = accept && (byte_count != '0) && (windowed || !mismatch);
    end
  end

endmodule

>>> design/dts_queue.sv
// Short request queue between the front end and the chunk generator.
// Depends on dts_pkg for the request type.
module dts_queue
  import dts_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
)(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  req_t          push_req,
  input  logic          pop,
  output req_t          head,
  output queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  req_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign status.full  = fill == CNT_W'(DEPTH);
  assign status.empty = fill == '0;
  assign head         = entries[rd_ptr];

  // Store incoming requests
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> design/dts_back.sv
// Chunk generator: takes queued requests, holds the window table and emits
// one chunk per cycle into an output register while it is free or being popped. Depends on dts_pkg.
module dts_back
  import dts_pkg::*;
#(
  parameter int MAX_BULK_BYTES     = MAX_BULK_BYTES_DEF,
  parameter int WINDOW_CHUNK_BYTES = WINDOW_CHUNK_BYTES_DEF,
  parameter int NUM_WINDOWS        = NUM_WINDOWS_DEF
)(
  input  logic                clk,
  input  logic                rst,
  input  req_t                head,
  input  queue_status_t       q_status,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output logic [ADDR_W-1:0]   chunk_remote_address,
  output logic [LOCAL_W-1:0]  chunk_local_address,
  output logic [BYTES_W-1:0]  chunk_bytes,
  output logic                last_chunk
);

  // Chunk caps, clamped so every length fits the chunk field
  localparam int BULK_CLAMP = (MAX_BULK_BYTES > 32752) ? 32752 : MAX_BULK_BYTES;
  localparam int BULK_RAW   = BULK_CLAMP - (BULK_CLAMP % 16);
  localparam int BULK_CAP   = (BULK_RAW < 16) ? 16 : BULK_RAW;
  localparam int WIN_HI     = (WINDOW_CHUNK_BYTES > 32767) ? 32767 : WINDOW_CHUNK_BYTES;
  localparam int WIN_CAP    = (WIN_HI < 1) ? 1 : WIN_HI;
  localparam int NW         = (NUM_WINDOWS < 1) ? 1 : NUM_WINDOWS;
  localparam int WIN_W      = (NW > 1) ? $clog2(NW) : 1;
  localparam int NCHUNK_W   = $clog2(RESULT_LIMIT);
  localparam int SUM_W      = 6;
  localparam int TABLE_DEPTH = 2 ** SLOT_W;

  logic [ADDR_W-1:0] window_table [TABLE_DEPTH];

  // Current request
  logic                busy;
  logic                windowed;
  logic [ADDR_W-1:0]   addr;
  logic [LOCAL_W-1:0]  local_addr;
  logic [COUNT_W-1:0]  remaining;
  logic [WIN_W-1:0]    window;
  logic [NCHUNK_W-1:0] nchunk;

  // Output register
  logic                out_valid;

  logic                emit;
  logic [COUNT_W-1:0]  win_len;
  logic [COUNT_W-1:0]  bulk_min;
  logic [COUNT_W-1:0]  small_len;
  logic [COUNT_W-1:0]  chunk_len;
  logic [COUNT_W-1:0]  remaining_next;
  logic                is_last;
  logic [LINE_BITS-1:0] line_off;
  logic [SUM_W-1:0]    slot_sum;
  logic [SLOT_W-1:0]   slot;
  logic [ADDR_W-1:0]   remote;

  assign empty = ~out_valid;
  assign emit  = busy & (~out_valid | pop);
  assign q_pop = ~busy & ~q_status.empty;

  // Chunk length for windowed and direct requests
  assign win_len  = (remaining < COUNT_W'(WIN_CAP)) ? remaining : COUNT_W'(WIN_CAP);
  assign bulk_min = (remaining > COUNT_W'(BULK_CAP)) ? COUNT_W'(BULK_CAP) : remaining;
  assign line_off = addr[LINE_BITS-1:0];

  always_comb begin
    if (line_off[2:0] == 3'd0 && remaining >= COUNT_W'(8)) begin
      small_len = COUNT_W'(8);
    end else if (line_off[1:0] == 2'd0 && remaining >= COUNT_W'(4)) begin
      small_len = COUNT_W'(4);
    end else if (line_off[0] == 1'b0 && remaining >= COUNT_W'(2)) begin
      small_len = COUNT_W'(2);
    end else begin
      small_len = COUNT_W'(1);
    end
  end

  always_comb begin
    if (windowed) begin
      chunk_len = win_len;
    end else if (line_off == '0 && remaining >= COUNT_W'(16)) begin
      chunk_len = {bulk_min[COUNT_W-1:LINE_BITS], {LINE_BITS{1'b0}}};
    end else begin
      chunk_len = small_len;
    end
  end

  assign remaining_next = remaining - chunk_len;
  assign is_last = (remaining_next == '0) || (nchunk == NCHUNK_W'(RESULT_LIMIT - 1));

  // Translate windowed addresses through the table
  assign slot_sum = SUM_W'(addr[OFFSET_BITS +: GROUP_W]) * SUM_W'(NW) + SUM_W'(window);
  assign slot     = slot_sum[SLOT_W-1:0];
  assign remote   = windowed
                    ? window_table[slot] + {{(ADDR_W-OFFSET_BITS){1'b0}}, addr[OFFSET_BITS-1:0]}
                    : addr;

  // Write table entries in request order
  always_ff @(posedge clk) begin
    if (q_pop && head.op == OP_TABLE_WRITE) begin
      window_table[head.slot] <= head.addr;
    end
  end

  // Load and step the current request
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop && head.op == OP_TRANSFER) begin
      busy <= 1'b1;
    end else if (emit && is_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      windowed   <= head.windowed;
      addr       <= head.addr;
      local_addr <= head.local_addr;
      remaining  <= head.size;
      window     <= '0;
      nchunk     <= '0;
    end else if (emit) begin
      addr       <= addr + ADDR_W'(chunk_len);
      local_addr <= local_addr + LOCAL_W'(chunk_len);
      remaining  <= remaining_next;
      window     <= (window == WIN_W'(NW - 1)) ? '0 : window + 1'b1;
      nchunk     <= nchunk + 1'b1;
    end
  end

  // Hold the chunk until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      chunk_remote_address <= remote;
      chunk_local_address  <= local_addr;
      chunk_bytes          <= BYTES_W'(chunk_len);
      last_chunk           <= is_last;
    end
  end

endmodule

>>> dv/dma_transfer_splitter_core_test.sv
// Self-checking testbench for dma_transfer_splitter_core: a chunk predictor
// and scoreboard, queue-style request and chunk drivers, and the base register.
// Depends on dts_pkg and the dma_transfer_splitter_core RTL only.
module dma_transfer_splitter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dts_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_NS      = 25_000_000;

  // Chunk caps as the default build applies them
  localparam int unsigned WIN_CAP = (WINDOW_CHUNK_BYTES_DEF > 32767) ? 32767 :
                                    (WINDOW_CHUNK_BYTES_DEF < 1) ? 1 : WINDOW_CHUNK_BYTES_DEF;
  localparam int unsigned BULK_RAW = (MAX_BULK_BYTES_DEF > 32752) ? 32752 : MAX_BULK_BYTES_DEF;
  localparam int unsigned BULK_CAP = ((BULK_RAW & 32'hFFFF_FFF0) < 16) ? 16 :
                                     (BULK_RAW & 32'hFFFF_FFF0);
  localparam int unsigned WIN_COUNT = (NUM_WINDOWS_DEF < 1) ? 1 : NUM_WINDOWS_DEF;

  typedef struct {
    req_op_t            op;
    logic [ADDR_W-1:0]  ea;
    logic [LOCAL_W-1:0] local_addr;
    logic [COUNT_W-1:0] count;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  wbase;
  } host_req_t;

  typedef struct {
    logic [ADDR_W-1:0]  remote;
    logic [LOCAL_W-1:0] local_addr;
    logic [BYTES_W-1:0] bytes;
    logic               last;
  } chunk_t;

  // Predicts the chunks of each accepted request and checks them in order
  class chunk_checker;
    logic [ADDR_W-1:0] space_base;
    logic [ADDR_W-1:0] window_table [16];
    chunk_t            pending_chunks [$];
    int unsigned       mismatches;

    function new();
      space_base = '0;
      mismatches = 0;
      foreach (window_table[i]) window_table[i] = '0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Translate a windowed address through the table
    function logic [ADDR_W-1:0] window_address(logic [ADDR_W-1:0] ea, int unsigned win);
      logic [ADDR_W-1:0] rel;
      int unsigned       slot;
      rel  = ea - space_base;
      slot = (int'(rel[OFFSET_BITS +: GROUP_W]) * WIN_COUNT + win) & 15;
      return window_table[slot] + {{(ADDR_W-OFFSET_BITS){1'b0}}, rel[OFFSET_BITS-1:0]};
    endfunction

    function void note_request(host_req_t rq);
      logic [ADDR_W-1:0]  ea;
      logic [LOCAL_W-1:0] la;
      int unsigned        left, d, eo, win, n;
      chunk_t             c;
      // Table writes take effect in request order
      if (rq.op == OP_TABLE_WRITE) begin
        window_table[rq.slot] = rq.wbase;
        return;
      end
      ea   = rq.ea;
      la   = rq.local_addr;
      left = rq.count;
      win  = 0;
      n    = 0;
      if ((ea & space_base) == space_base) begin
        // Windowed: chunks of up to WIN_CAP bytes, window advances per chunk
        while (left != 0 && n < RESULT_LIMIT) begin
          d = (left < WIN_CAP) ? left : WIN_CAP;
          c.remote     = window_address(ea, win);
          c.local_addr = la;
          c.bytes      = BYTES_W'(d);
          c.last       = (left == d) || (n + 1 == RESULT_LIMIT);
          pending_chunks.push_back(c);
          n++;
          ea   = ea + d;
          la   = la + LOCAL_W'(d);
          left = left - d;
          win  = (win + 1) % WIN_COUNT;
        end
      end else begin
        // Direct: bulk on line boundaries, aligned pieces elsewhere
        while (left != 0 && n < RESULT_LIMIT) begin
          eo = ea[LINE_BITS-1:0];
          if (eo != la[LINE_BITS-1:0]) break;
          if (eo == 0 && left >= 16) begin
            d = (left > BULK_CAP) ? BULK_CAP : left;
            d = d & 32'hFFFF_FFF0;
          end else begin
            d = 8;
            while (d > 1 && ((eo & (d - 1)) != 0 || d > left || eo + d > 16)) d = d >> 1;
          end
          c.remote     = ea;
          c.local_addr = la;
          c.bytes      = BYTES_W'(d);
          c.last       = (left == d) || (n + 1 == RESULT_LIMIT);
          pending_chunks.push_back(c);
          n++;
          ea   = ea + d;
          la   = la + LOCAL_W'(d);
          left = left - d;
        end
      end
    endfunction

    function void check_chunk(chunk_t got);
      chunk_t want;
      if (pending_chunks.size() == 0) begin
        flag($sformatf("unexpected chunk: remote %h local %h bytes %0d last %b",
                       got.remote, got.local_addr, got.bytes, got.last));
        return;
      end
      want = pending_chunks.pop_front();
      if (got.remote !== want.remote || got.local_addr !== want.local_addr ||
          got.bytes !== want.bytes || got.last !== want.last)
        flag($sformatf({"chunk mismatch: expected remote %h local %h bytes %0d last %b,",
                        " got remote %h local %h bytes %0d last %b"},
                       want.remote, want.local_addr, want.bytes, want.last,
                       got.remote, got.local_addr, got.bytes, got.last));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [ADDR_W-1:0]     pwdata;
  logic [ADDR_W-1:0]     prdata;
  logic                  pready;
  logic                  push;
  logic                  full;
  logic                  mode;
  logic [ADDR_W-1:0]     effective_address;
  logic [LOCAL_W-1:0]    local_address;
  logic [COUNT_W-1:0]    byte_count;
  logic [SLOT_W-1:0]     window_slot;
  logic [ADDR_W-1:0]     window_base;
  logic                  empty;
  logic                  pop;
  logic [ADDR_W-1:0]     chunk_remote_address;
  logic [LOCAL_W-1:0]    chunk_local_address;
  logic [BYTES_W-1:0]    chunk_bytes;
  logic                  last_chunk;

  chunk_checker sb = new();
  bit           push_steady;

  dma_transfer_splitter_core i_dut (.*);

  initial clk = 1'b0;
  always #(CLK_PERIOD/2) clk = ~clk;

  // Build a transfer request
  function automatic host_req_t transfer(logic [ADDR_W-1:0] ea, logic [LOCAL_W-1:0] la,
                                         logic [COUNT_W-1:0] cnt);
    host_req_t rq;
    rq.op         = OP_TRANSFER;
    rq.ea         = ea;
    rq.local_addr = la;
    rq.count      = cnt;
    rq.slot       = SLOT_W'($urandom);
    rq.wbase      = {$urandom, $urandom};
    return rq;
  endfunction

  // Build a table-write request
  function automatic host_req_t table_write(logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] value);
    host_req_t rq;
    rq       = transfer({$urandom, $urandom}, LOCAL_W'($urandom), COUNT_W'($urandom));
    rq.op    = OP_TABLE_WRITE;
    rq.slot  = slot;
    rq.wbase = value;
    return rq;
  endfunction

  // Mostly small counts, the occasional large one
  function automatic logic [COUNT_W-1:0] random_count();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick < 14) return COUNT_W'($urandom_range(1, 64));
    if (pick < 18) return COUNT_W'($urandom_range(65, 2100));
    if (pick == 18) return COUNT_W'($urandom_range(2101, 20000));
    return COUNT_W'($urandom_range(20001, 65535));
  endfunction

  // Random request shaped for the current base: windowed or direct, mostly well formed
  function automatic host_req_t random_request(logic [ADDR_W-1:0] base);
    host_req_t   rq;
    int unsigned bitno;
    if ($urandom_range(0, 9) == 0)
      return table_write(SLOT_W'($urandom), {$urandom, $urandom});
    rq = transfer({$urandom, $urandom}, LOCAL_W'($urandom), random_count());
    if ($urandom_range(0, 2) == 0) rq.ea[LINE_BITS-1:0] = '0;
    if (base == '0 || $urandom_range(0, 1) == 0) begin
      rq.ea = rq.ea | base;
    end else begin
      // clear one base bit so the request goes direct
      do bitno = $urandom_range(0, ADDR_W-1); while (!base[bitno]);
      rq.ea[bitno] = 1'b0;
      if ($urandom_range(0, 9) != 0) rq.local_addr[LINE_BITS-1:0] = rq.ea[LINE_BITS-1:0];
    end
    return rq;
  endfunction

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(host_req_t rq);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) push_steady = !push_steady;
    gap = push_steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode              <= rq.op;
    effective_address <= rq.ea;
    local_address     <= rq.local_addr;
    byte_count        <= rq.count;
    window_slot       <= rq.slot;
    window_base       <= rq.wbase;
    push              <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_request(rq);
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) send_request(random_request(sb.space_base));
  endtask

  // Wait for every predicted chunk, then let dropped requests clear
  task automatic wait_idle();
    while (sb.pending_chunks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the window-space base, then read it back
  task automatic set_space_base(logic [ADDR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_WINDOW_SPACE_BASE;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.space_base = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== value)
      sb.flag($sformatf("base readback: expected %h got %h", value, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain chunks with random stalls
  initial begin : chunk_drain
    int unsigned gap;
    bit          steady;
    chunk_t      got;
    steady = 1'b0;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got.remote     = chunk_remote_address;
      got.local_addr = chunk_local_address;
      got.bytes      = chunk_bytes;
      got.last       = last_chunk;
      sb.check_chunk(got);
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("dma_transfer_splitter_core test failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned       i;
    logic [ADDR_W-1:0] sparse;
    push_steady = 1'b0;
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    push              <= 1'b0;
    mode              <= 1'b0;
    effective_address <= '0;
    local_address     <= '0;
    byte_count        <= '0;
    window_slot       <= '0;
    window_base       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole table so no windowed chunk reads an unwritten entry
    for (i = 0; i < 16; i++)
      send_request(table_write(SLOT_W'(i), (i == 0) ? '0 : (i == 1) ? '1 :
                                           {$urandom, $urandom}));

    // Reset base: everything is windowed
    send_request(transfer('0, '0, 16'd1));
    send_request(transfer(64'hFFFF_FFFF_FFFF_FF00, 18'h3FF00, 16'hFFFF));
    send_request(transfer(64'h0000_0000_03FF_FE00, 18'h00123, 16'd2053));
    send_request(transfer(64'h1234_5678_9ABC_DEF0, 18'h2AAAA, 16'd0));
    send_request(transfer({$urandom, $urandom}, 18'h15555, 16'd1024));
    send_request(transfer(64'h0000_0000_1C00_0000, '0, 16'd1025));
    send_request(table_write('0, 64'h8000_0000_0000_0000));
    send_request(transfer('0, 18'h00010, 16'd10));
    send_random(31);
    push <= 1'b0;
    wait_idle();

    // One low base bit: direct path reachable, including address wrap
    set_space_base(64'h0000_0000_0000_0010);
    send_request(transfer('0, '0, 16'hFFFF));
    send_request(transfer(64'h0000_0000_0000_0001, 18'h00001, 16'd40));
    send_request(transfer(64'h0000_0000_0000_0003, 18'h00005, 16'd100));
    send_request(transfer(64'h0000_0000_0000_0020, 18'h00020, 16'd0));
    send_request(transfer(64'hFFFF_FFFF_FFFF_FFE9, 18'h3FFE9, 16'd64));
    send_request(transfer(64'h0000_0000_0000_002F, 18'h0000F, 16'd1));
    send_request(transfer(64'h0000_0000_0000_0040, 18'h00040, 16'd16));
    send_request(transfer(64'h0000_0000_0000_0040, 18'h00080, 16'd15));
    send_request(transfer(64'h0000_0000_0000_0010, 18'h00003, 16'd100));
    send_random(31);
    push <= 1'b0;
    wait_idle();

    // Sparse random base
    sparse = '0;
    repeat ($urandom_range(1, 6)) sparse[$urandom_range(0, ADDR_W-1)] = 1'b1;
    set_space_base(sparse);
    send_random(31);
    push <= 1'b0;
    wait_idle();

    // All-ones base: only the top address is windowed
    set_space_base('1);
    send_request(transfer('1, LOCAL_W'($urandom), 16'd3000));
    send_request(transfer('0, '0, 16'd33));
    send_random(31);
    push <= 1'b0;
    wait_idle();

    if (sb.mismatches == 0 && sb.pending_chunks.size() == 0)
      $display("dma_transfer_splitter_core test passed");
    else
      $display("dma_transfer_splitter_core test failed");
    $finish;
  end

endmodule
